>>> src/mecanum_wheel_duty_mixer_unit_assert.svh
// Assertion macros for the mecanum wheel duty mixer.
`ifndef MECANUM_WHEEL_DUTY_MIXER_UNIT_ASSERT_SVH
`define MECANUM_WHEEL_DUTY_MIXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MDM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mdm assertion failed");
`define MDM_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("mdm assertion failed");
`else
`define MDM_ASSERT(lbl, prop)
`define MDM_ASSERT_NR(lbl, prop)
`endif
`endif

>>> src/mdm_pkg.sv
// Shared constants, types and helpers of the mecanum wheel duty mixer.
`timescale 1ns / 1ps
`default_nettype none
package mdm_pkg;
  localparam int unsigned WHEEL_SPEED_WIDTH = 24;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned DGAIN_W    = 16;
  localparam int unsigned STEP_W     = 23;
  localparam int unsigned DLIM_W     = 14;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned DUTY_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned NWHEEL     = 4;

  localparam int unsigned T_W    = VEL_W + GAIN_W + 2;
  localparam int unsigned EXT_W  = T_W + WHEEL_SPEED_WIDTH;
  localparam int unsigned MA_W   = WHEEL_SPEED_WIDTH + 1;
  localparam int unsigned MB_W   = STEP_W;
  localparam int unsigned MP_W   = MA_W + MB_W;
  localparam int unsigned MCNT_W = $clog2(MB_W);
  localparam int unsigned DCNT_W = $clog2(MP_W);
  localparam int unsigned OFF_SHIFT = 16;

  localparam logic [GAIN_W-1:0]  LIN_GAIN_RST  = 20'd8213;
  localparam logic [GAIN_W-1:0]  ROT_GAIN_RST  = 20'd52267;
  localparam logic [DGAIN_W-1:0] DUTY_GAIN_RST = 16'd7646;
  localparam logic [STEP_W-1:0]  MAX_STEP_RST  = 23'd3200;
  localparam logic [DLIM_W-1:0]  DUTY_LIM_RST  = 14'd12288;
  localparam logic [DLIM_W-1:0]  DUTY_CENTER   = 14'd12800;
  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 15'd25600;

  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MASK     = 3'd6;

  typedef logic signed [WHEEL_SPEED_WIDTH-1:0] speed_t;
  typedef logic signed [EXT_W-1:0] ext_t;

  localparam ext_t SPD_MAX = ext_t'({(WHEEL_SPEED_WIDTH-1){1'b1}});
  localparam ext_t SPD_MIN = ~SPD_MAX;

  function automatic speed_t sat_speed(input ext_t v);
    speed_t r;
    if (v > SPD_MAX) begin
      r = SPD_MAX[WHEEL_SPEED_WIDTH-1:0];
    end else if (v < SPD_MIN) begin
      r = SPD_MIN[WHEEL_SPEED_WIDTH-1:0];
    end else begin
      r = v[WHEEL_SPEED_WIDTH-1:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> src/mecanum_wheel_duty_mixer_unit.sv
// Top level of the mecanum wheel duty mixer: sequencer, state and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_duty_mixer_unit_assert.svh"
// Takes one body velocity command per transaction and returns four wheel duties.
// A sequencer drives one bit-serial multiplier (23 shift-add steps) and one
// restoring divider (48 steps). A command needs three products for the body
// terms, a mixing step for each of the four wheels and four duty products. When
// the step limiter engages it adds a product and a quotient per wheel, and
// scaling the duty offsets adds another product and quotient per wheel. The
// result stalls while an earlier result still waits unaccepted in the output
// register; it becomes valid in the same cycle as the next command can be taken.
// Only one command is in flight.
// A finished result waits in the output register while the next command is taken.
module mecanum_wheel_duty_mixer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mdm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mdm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mdm_pkg::VEL_W-1:0]  velocity_x_i,
  input  logic signed [mdm_pkg::VEL_W-1:0]  velocity_y_i,
  input  logic signed [mdm_pkg::VEL_W-1:0]  velocity_rot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mdm_pkg::DUTY_W-1:0]        duty_front_left_o,
  output logic [mdm_pkg::DUTY_W-1:0]        duty_front_right_o,
  output logic [mdm_pkg::DUTY_W-1:0]        duty_back_left_o,
  output logic [mdm_pkg::DUTY_W-1:0]        duty_back_right_o,
  output logic                              duty_scaled_o,
  output logic                              step_limited_o
);
  import mdm_pkg::*;

  localparam int unsigned W = WHEEL_SPEED_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULV = 4'd1;
  localparam logic [3:0] S_MIX  = 4'd2;
  localparam logic [3:0] S_LDEC = 4'd3;
  localparam logic [3:0] S_LMUL = 4'd4;
  localparam logic [3:0] S_LDIV = 4'd5;
  localparam logic [3:0] S_DMUL = 4'd6;
  localparam logic [3:0] S_SDEC = 4'd7;
  localparam logic [3:0] S_SMUL = 4'd8;
  localparam logic [3:0] S_SDIV = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // configuration
  logic [GAIN_W-1:0]  lin_gain_q, rot_gain_q;
  logic [DGAIN_W-1:0] duty_gain_q;
  logic               step_en_q;
  logic [STEP_W-1:0]  max_step_q;
  logic [DLIM_W-1:0]  duty_lim_q;
  logic [MASK_W-1:0]  mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q  <= LIN_GAIN_RST;
      rot_gain_q  <= ROT_GAIN_RST;
      duty_gain_q <= DUTY_GAIN_RST;
      step_en_q   <= 1'b0;
      max_step_q  <= MAX_STEP_RST;
      duty_lim_q  <= DUTY_LIM_RST;
      mask_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINEAR_GAIN:   lin_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_ROTATION_GAIN: rot_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_DUTY_GAIN:     duty_gain_q <= cfg_data_i[DGAIN_W-1:0];
        REG_STEP_ENABLE:   step_en_q   <= cfg_data_i[0];
        REG_MAX_STEP:      max_step_q  <= cfg_data_i[STEP_W-1:0];
        REG_DUTY_LIMIT:    duty_lim_q  <= cfg_data_i[DLIM_W-1:0];
        REG_SIGN_MASK:     mask_q      <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [3:0] state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       mul_go_q, mul_go_d, div_go_q, div_go_d;
  logic       limited_q, limited_d, scaled_q, scaled_d;
  logic       out_valid_q, out_valid_d;

  // datapath registers
  logic signed [VEL_W-1:0] vx_q, vy_q, vr_q;
  logic signed [T_W-1:0]   tx_q, ty_q, tr_q, tx_d, ty_d, tr_d;
  speed_t                  last_q [NWHEEL];
  speed_t                  last_d [NWHEEL];
  logic signed [W:0]       delta_q [NWHEEL];
  logic signed [W:0]       delta_d [NWHEEL];
  logic [W:0]              dmax_q, dmax_d;
  logic [W-1:0]            offmag_q [NWHEEL];
  logic [W-1:0]            offmag_d [NWHEEL];
  logic                    offneg_q [NWHEEL];
  logic                    offneg_d [NWHEEL];
  logic [W-1:0]            omax_q, omax_d;
  logic [DLIM_W-1:0]       mres_q [NWHEEL];
  logic [DLIM_W-1:0]       mres_d [NWHEEL];
  logic [DUTY_W-1:0]       duty_q [NWHEEL];
  logic [DUTY_W-1:0]       duty_d [NWHEEL];
  logic                    scaled_out_q, limited_out_q;

  // shared units
  logic [MA_W-1:0] mul_a, div_den;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_prod, div_quo;
  logic            mul_done, div_done;

  mdm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (mul_prod),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // velocity term
  logic signed [VEL_W-1:0] vel_sel;
  logic signed [VEL_W:0]   vel_ext;
  logic [VEL_W:0]          vel_mag;
  logic [GAIN_W-1:0]       gain_sel;
  logic signed [T_W-1:0]   prod_t, term;

  always_comb begin
    case (k_q)
      2'd0:    vel_sel = vx_q;
      2'd1:    vel_sel = vy_q;
      default: vel_sel = vr_q;
    endcase
  end
  assign vel_ext  = {vel_sel[VEL_W-1], vel_sel};
  assign vel_mag  = vel_ext[VEL_W] ? -vel_ext : vel_ext;
  assign gain_sel = (k_q == 2'd2) ? rot_gain_q : lin_gain_q;
  assign prod_t   = mul_prod[T_W-1:0];
  assign term     = vel_ext[VEL_W] ? -prod_t : prod_t;

  // mixing row for wheel k: FL, FR, BL, BR
  logic signed [T_W-1:0] mix_sum, mix_q8;
  speed_t                target, last_k;
  logic signed [W:0]     delta_new, delta_k;
  logic [W:0]            dabs_new, dabs_k;

  assign last_k    = last_q[k_q];
  assign mix_sum   = (k_q[1] ? -tx_q : tx_q) + (k_q[0] ? -ty_q : ty_q) + tr_q;
  assign mix_q8    = mix_sum[T_W-1] ? ((mix_sum + T_W'(255)) >>> 8) : (mix_sum >>> 8);
  assign target    = sat_speed(ext_t'(mix_q8));
  assign delta_new = {target[W-1], target} - {last_k[W-1], last_k};
  assign dabs_new  = delta_new[W] ? -delta_new : delta_new;
  assign delta_k   = delta_q[k_q];
  assign dabs_k    = delta_k[W] ? -delta_k : delta_k;

  // limited step
  ext_t   qstep_abs, qstep;
  speed_t lim_upd;
  assign qstep_abs = ext_t'({1'b0, div_quo[W:0]});
  assign qstep     = delta_k[W] ? -qstep_abs : qstep_abs;
  assign lim_upd   = sat_speed(ext_t'(last_k) + qstep);

  // duty offset
  logic signed [W:0] w_ext, w_sgn, w_neg_v;
  logic [W-1:0]      w_mag, off_new;
  logic              w_neg;
  assign w_ext   = {last_k[W-1], last_k};
  assign w_sgn   = mask_q[k_q] ? -w_ext : w_ext;
  assign w_neg   = w_sgn[W];
  assign w_neg_v = -w_sgn;
  assign w_mag   = w_neg ? w_neg_v[W-1:0] : w_sgn[W-1:0];
  assign off_new = mul_prod[OFF_SHIFT +: W];

  logic [DLIM_W-1:0] lim;
  assign lim = (duty_lim_q > DUTY_CENTER) ? DUTY_CENTER : duty_lim_q;

  always_comb begin
    case (state_q)
      S_MULV: begin
        mul_a = MA_W'(vel_mag);
        mul_b = MB_W'(gain_sel);
      end
      S_LMUL: begin
        mul_a = MA_W'(dabs_k);
        mul_b = max_step_q;
      end
      S_DMUL: begin
        mul_a = MA_W'(w_mag);
        mul_b = MB_W'(duty_gain_q);
      end
      default: begin
        mul_a = MA_W'(offmag_q[k_q]);
        mul_b = MB_W'(lim);
      end
    endcase
  end
  assign div_den = (state_q == S_LDIV) ? MA_W'(dmax_q) : MA_W'(omax_q);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    mul_go_d    = 1'b0;
    div_go_d    = 1'b0;
    limited_d   = limited_q;
    scaled_d    = scaled_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tx_d        = tx_q;
    ty_d        = ty_q;
    tr_d        = tr_q;
    dmax_d      = dmax_q;
    omax_d      = omax_q;
    for (int i = 0; i < NWHEEL; i++) begin
      last_d[i]   = last_q[i];
      delta_d[i]  = delta_q[i];
      offmag_d[i] = offmag_q[i];
      offneg_d[i] = offneg_q[i];
      mres_d[i]   = mres_q[i];
      duty_d[i]   = duty_q[i];
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          k_d      = 2'd0;
          mul_go_d = 1'b1;
          state_d  = S_MULV;
        end
      end
      S_MULV: begin
        if (mul_done) begin
          case (k_q)
            2'd0:    tx_d = term;
            2'd1:    ty_d = term;
            default: tr_d = term;
          endcase
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            state_d = S_MIX;
          end else begin
            k_d      = k_q + 2'd1;
            mul_go_d = 1'b1;
          end
        end
      end
      S_MIX: begin
        delta_d[k_q] = delta_new;
        if (k_q == 2'd0 || dabs_new > dmax_q) begin
          dmax_d = dabs_new;
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_LDEC;
        end
      end
      S_LDEC: begin
        k_d       = 2'd0;
        mul_go_d  = 1'b1;
        limited_d = step_en_q && (dmax_q != '0) && (dmax_q >= (W + 1)'(max_step_q));
        if (limited_d) begin
          state_d = S_LMUL;
        end else begin
          for (int i = 0; i < NWHEEL; i++) begin
            last_d[i] = sat_speed(ext_t'(last_q[i]) + ext_t'(delta_q[i]));
          end
          state_d = S_DMUL;
        end
      end
      S_LMUL: begin
        if (mul_done) begin
          div_go_d = 1'b1;
          state_d  = S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          last_d[k_q] = lim_upd;
          k_d         = k_q + 2'd1;
          mul_go_d    = 1'b1;
          state_d     = (k_q == 2'd3) ? S_DMUL : S_LMUL;
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          offmag_d[k_q] = off_new;
          offneg_d[k_q] = w_neg;
          if (k_q == 2'd0 || off_new > omax_q) begin
            omax_d = off_new;
          end
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_d = S_SDEC;
          end else begin
            mul_go_d = 1'b1;
          end
        end
      end
      S_SDEC: begin
        k_d      = 2'd0;
        scaled_d = (omax_q != '0) && (omax_q >= W'(lim));
        if (scaled_d) begin
          mul_go_d = 1'b1;
          state_d  = S_SMUL;
        end else begin
          for (int i = 0; i < NWHEEL; i++) begin
            mres_d[i] = (offmag_q[i] > W'(DUTY_CENTER)) ? DUTY_CENTER
                                                      : offmag_q[i][DLIM_W-1:0];
          end
          state_d = S_OUT;
        end
      end
      S_SMUL: begin
        if (mul_done) begin
          div_go_d = 1'b1;
          state_d  = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_done) begin
          mres_d[k_q] = div_quo[DLIM_W-1:0];
          k_d         = k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_d = S_OUT;
          end else begin
            mul_go_d = 1'b1;
            state_d  = S_SMUL;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          for (int i = 0; i < NWHEEL; i++) begin
            duty_d[i] = offneg_q[i] ? DUTY_W'(DUTY_CENTER) - DUTY_W'(mres_q[i])
                                    : DUTY_W'(DUTY_CENTER) + DUTY_W'(mres_q[i]);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      limited_q   <= 1'b0;
      scaled_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NWHEEL; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      limited_q   <= limited_d;
      scaled_q    <= scaled_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NWHEEL; i++) begin
        last_q[i] <= last_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      vx_q <= velocity_x_i;
      vy_q <= velocity_y_i;
      vr_q <= velocity_rot_i;
    end
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    tr_q   <= tr_d;
    dmax_q <= dmax_d;
    omax_q <= omax_d;
    for (int i = 0; i < NWHEEL; i++) begin
      delta_q[i]  <= delta_d[i];
      offmag_q[i] <= offmag_d[i];
      offneg_q[i] <= offneg_d[i];
      mres_q[i]   <= mres_d[i];
      duty_q[i]   <= duty_d[i];
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      scaled_out_q  <= scaled_q;
      limited_out_q <= limited_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign duty_front_left_o  = duty_q[0];
  assign duty_front_right_o = duty_q[1];
  assign duty_back_left_o   = duty_q[2];
  assign duty_back_right_o  = duty_q[3];
  assign duty_scaled_o      = scaled_out_q;
  assign step_limited_o     = limited_out_q;

  logic mul_wait_st, div_wait_st, duties_in_range;
  assign mul_wait_st     = (state_q == S_MULV) || (state_q == S_LMUL) ||
                           (state_q == S_DMUL) || (state_q == S_SMUL);
  assign div_wait_st     = (state_q == S_LDIV) || (state_q == S_SDIV);
  assign duties_in_range = (duty_front_left_o <= DUTY_MAX) &&
                           (duty_front_right_o <= DUTY_MAX) &&
                           (duty_back_left_o <= DUTY_MAX) &&
                           (duty_back_right_o <= DUTY_MAX);

  `MDM_ASSERT(a_mul_done_state, mul_done |-> mul_wait_st)
  `MDM_ASSERT(a_div_done_state, div_done |-> div_wait_st)
  `MDM_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == S_MULV && mul_go_q))
  `MDM_ASSERT(a_units_exclusive, !(mul_go_q && div_go_q))
  `MDM_ASSERT(a_duty_range, out_valid_o |-> duties_in_range)
endmodule
`default_nettype wire

>>> src/mdm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mdm_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mdm_pkg::MA_W-1:0]  a_i,
  input  logic [mdm_pkg::MB_W-1:0]  b_i,
  output logic                      done_o,
  output logic [mdm_pkg::MP_W-1:0]  prod_o
);
  import mdm_pkg::*;

  logic [MA_W-1:0]   a_q, hi_q, hi_d;
  logic [MB_W-1:0]   lo_q, lo_d;
  logic [MCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [MA_W:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MA_W:1];
      lo_d  = {sum[0], lo_q[MB_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MCNT_W'(MB_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};
endmodule
`default_nettype wire

>>> src/mdm_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mdm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mdm_pkg::MP_W-1:0]  num_i,
  input  logic [mdm_pkg::MA_W-1:0]  den_i,
  output logic                      done_o,
  output logic [mdm_pkg::MP_W-1:0]  quo_o
);
  import mdm_pkg::*;

  logic [MA_W-1:0]   rem_q, rem_d, den_q;
  logic [MP_W-1:0]   num_q, num_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [MA_W:0]     trial, diff;
  logic              ge;

  assign trial = {rem_q, num_q[MP_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[MA_W-1:0] : trial[MA_W-1:0];
      num_d = {num_q[MP_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(MP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule
`default_nettype wire
